// ----- sv/cit_pkg.sv -----
// Shared constants, codes and types of the counted id table.
package cit_pkg;

  // Default sizes
  localparam int unsigned DepthDefault     = 128;
  localparam int unsigned IdBitsDefault    = 10;
  localparam int unsigned CountBitsDefault = 16;
  localparam int unsigned PosBitsDefault   = $clog2(DepthDefault);
  localparam int unsigned OccBitsDefault   = $clog2(DepthDefault + 1);

  // Cells per group of the registered gather tree
  localparam int unsigned GatherGroup = 16;

  // Action codes
  localparam logic [1:0] ActAdd    = 2'd0;
  localparam logic [1:0] ActRemove = 2'd1;
  localparam logic [1:0] ActFind   = 2'd2;
  localparam logic [1:0] ActClear  = 2'd3;

  // Status codes
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StInvalid = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;
  localparam logic [1:0] StAbsent  = 2'd3;

  // Command broadcast to every cell
  typedef enum logic [1:0] {
    CELL_NOP,
    CELL_WRITE,
    CELL_APPEND,
    CELL_SHIFT
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     compare;
  } cell_cmd_t;

endpackage

// ----- sv/cit_req_if.sv -----
// Request channel of the counted id table.
interface cit_req_if #(
  parameter int unsigned ID_BITS    = cit_pkg::IdBitsDefault,
  parameter int unsigned COUNT_BITS = cit_pkg::CountBitsDefault
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            action;
  logic [ID_BITS-1:0]    item_id;
  logic [COUNT_BITS-1:0] amount;
  logic                  remove_all;

  modport source (output valid, action, item_id, amount, remove_all, input ready);
  modport sink   (input valid, action, item_id, amount, remove_all, output ready);
endinterface

// ----- sv/cit_rsp_if.sv -----
// Response channel of the counted id table.
interface cit_rsp_if #(
  parameter int unsigned POS_BITS   = cit_pkg::PosBitsDefault,
  parameter int unsigned COUNT_BITS = cit_pkg::CountBitsDefault,
  parameter int unsigned OCC_BITS   = cit_pkg::OccBitsDefault
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [POS_BITS-1:0]   position;
  logic [COUNT_BITS-1:0] entry_amount;
  logic [OCC_BITS-1:0]   occupancy;

  modport source (output valid, status, position, entry_amount, occupancy, input ready);
  modport sink   (input valid, status, position, entry_amount, occupancy, output ready);
endinterface

// ----- sv/cit_cell.sv -----
// One table cell: holds an (id, count) entry, matches it and shifts it left.
module cit_cell #(
  parameter int unsigned ID_BITS    = cit_pkg::IdBitsDefault,
  parameter int unsigned COUNT_BITS = cit_pkg::CountBitsDefault,
  parameter int unsigned POS_BITS   = 7,
  parameter int unsigned OCC_BITS   = 8,
  parameter int unsigned INDEX      = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cit_pkg::cell_cmd_t    cmd_i,
  input  logic [POS_BITS-1:0]   idx_i,
  input  logic [ID_BITS-1:0]    id_i,
  input  logic [COUNT_BITS-1:0] count_i,
  input  logic [OCC_BITS-1:0]   total_i,
  input  logic [ID_BITS-1:0]    nxt_id_i,
  input  logic [COUNT_BITS-1:0] nxt_count_i,
  output logic [ID_BITS-1:0]    id_o,
  output logic [COUNT_BITS-1:0] count_o,
  output logic                  hit_o
);

  localparam logic [POS_BITS-1:0] MyPos = POS_BITS'(INDEX);
  localparam logic [OCC_BITS-1:0] MyOcc = OCC_BITS'(INDEX);

  logic [ID_BITS-1:0]    id_q;
  logic [COUNT_BITS-1:0] count_q;
  logic                  hit_q;
  logic                  live;
  logic                  here;

  assign live = MyOcc < total_i;
  assign here = idx_i == MyPos;

  // Capture the match of a live entry against the key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cmd_i.compare) begin
      hit_q <= live && (id_q == id_i);
    end
  end

  // Write, append or take the right neighbour's entry
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      cit_pkg::CELL_WRITE: begin
        if (here) count_q <= count_i;
      end
      cit_pkg::CELL_APPEND: begin
        if (here) begin
          id_q    <= id_i;
          count_q <= count_i;
        end
      end
      cit_pkg::CELL_SHIFT: begin
        if (MyPos >= idx_i) begin
          id_q    <= nxt_id_i;
          count_q <= nxt_count_i;
        end
      end
      default: begin
      end
    endcase
  end

  assign id_o    = id_q;
  assign count_o = count_q;
  assign hit_o   = hit_q;

endmodule

// ----- sv/cit_gather.sv -----
// Registered two-level tree that picks the index and count of the matching cell.
module cit_gather #(
  parameter int unsigned TABLE_DEPTH = cit_pkg::DepthDefault,
  parameter int unsigned COUNT_BITS  = cit_pkg::CountBitsDefault,
  parameter int unsigned POS_BITS    = 7
) (
  input  logic                  clk_i,
  input  logic [TABLE_DEPTH-1:0] hit_i,
  input  logic [COUNT_BITS-1:0] count_i [TABLE_DEPTH],
  output logic                  hit_o,
  output logic [POS_BITS-1:0]   idx_o,
  output logic [COUNT_BITS-1:0] count_o
);

  localparam int unsigned Groups = (TABLE_DEPTH + cit_pkg::GatherGroup - 1) / cit_pkg::GatherGroup;
  localparam int unsigned Padded = Groups * cit_pkg::GatherGroup;

  logic [Padded-1:0]     hit_pad;
  logic [COUNT_BITS-1:0] cnt_pad [Padded];
  logic                  grp_hit_q [Groups];
  logic [POS_BITS-1:0]   grp_idx_q [Groups];
  logic [COUNT_BITS-1:0] grp_cnt_q [Groups];
  logic                  hit_d;
  logic [POS_BITS-1:0]   idx_d;
  logic [COUNT_BITS-1:0] cnt_d;
  logic                  hit_q;
  logic [POS_BITS-1:0]   idx_q;
  logic [COUNT_BITS-1:0] cnt_q;

  // Pad the cell row to whole groups
  for (genvar e = 0; e < Padded; e++) begin : g_pad
    if (e < TABLE_DEPTH) begin : g_real
      assign hit_pad[e] = hit_i[e];
      assign cnt_pad[e] = hit_i[e] ? count_i[e] : '0;
    end else begin : g_fill
      assign hit_pad[e] = 1'b0;
      assign cnt_pad[e] = '0;
    end
  end

  // First level: one OR per group, registered
  for (genvar g = 0; g < Groups; g++) begin : g_grp
    logic                  h;
    logic [POS_BITS-1:0]   ix;
    logic [COUNT_BITS-1:0] c;
    always_comb begin
      h  = 1'b0;
      ix = '0;
      c  = '0;
      for (int j = 0; j < cit_pkg::GatherGroup; j++) begin
        h = h | hit_pad[g*cit_pkg::GatherGroup + j];
        c = c | cnt_pad[g*cit_pkg::GatherGroup + j];
        if (hit_pad[g*cit_pkg::GatherGroup + j]) begin
          ix = ix | POS_BITS'(g*cit_pkg::GatherGroup + j);
        end
      end
    end
    always_ff @(posedge clk_i) begin
      grp_hit_q[g] <= h;
      grp_idx_q[g] <= ix;
      grp_cnt_q[g] <= c;
    end
  end

  // Second level: OR across groups
  always_comb begin
    hit_d = 1'b0;
    idx_d = '0;
    cnt_d = '0;
    for (int g = 0; g < Groups; g++) begin
      hit_d = hit_d | grp_hit_q[g];
      idx_d = idx_d | grp_idx_q[g];
      cnt_d = cnt_d | grp_cnt_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
    idx_q <= idx_d;
    cnt_q <= cnt_d;
  end

  assign hit_o   = hit_q;
  assign idx_o   = idx_q;
  assign count_o = cnt_q;

endmodule

// ----- sv/counted_id_table_top.sv -----
// Top level of the counted id table: control, cell row and result register.
//
//   channel  dir  handshake     payload
//   req_i    in   valid/ready   action, item_id, amount, remove_all
//   rsp_o    out  valid/ready   status, position, entry_amount, occupancy
//   cfg      in   cfg_we_i      cfg_wdata_i (id_limit)
//
// One item at a time: the result is loaded after the transfer in through the steps
// cell match, group gather, final gather and apply, which follow the registered match
// tree; the next transfer is taken only once the apply step is through.
// A result waiting on rsp_o does not block the next transfer in; only the apply
// step waits for the result register to free. Reset empties the table and sets
// id_limit to 2^ID_BITS; entry storage is left as it is.
module counted_id_table_top #(
  parameter int unsigned TABLE_DEPTH = cit_pkg::DepthDefault,
  parameter int unsigned ID_BITS     = cit_pkg::IdBitsDefault,
  parameter int unsigned COUNT_BITS  = cit_pkg::CountBitsDefault,
  parameter int unsigned POS_BITS    = $clog2(TABLE_DEPTH),
  parameter int unsigned OCC_BITS    = $clog2(TABLE_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  cit_req_if.sink          req_i,
  cit_rsp_if.source        rsp_o,
  input  logic             cfg_we_i,
  input  logic [ID_BITS:0] cfg_wdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_GATHER,
    S_PICK,
    S_APPLY
  } state_e;

  localparam logic [OCC_BITS-1:0] FullOcc = OCC_BITS'(TABLE_DEPTH);

  state_e                state_q;
  logic [ID_BITS:0]      limit_q;
  logic [OCC_BITS-1:0]   total_q;
  logic [1:0]            act_q;
  logic [ID_BITS-1:0]    id_q;
  logic [COUNT_BITS-1:0] amt_q;
  logic                  all_q;
  logic                  bad_q;

  logic                  out_valid_q;
  logic [1:0]            out_status_q;
  logic [POS_BITS-1:0]   out_pos_q;
  logic [COUNT_BITS-1:0] out_cnt_q;
  logic [OCC_BITS-1:0]   out_occ_q;

  cit_pkg::cell_cmd_t    cmd;
  logic [POS_BITS-1:0]   cmd_idx;
  logic [COUNT_BITS-1:0] cmd_cnt;
  logic [ID_BITS-1:0]    cell_id  [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] cell_cnt [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] cell_hit;

  logic                  hit;
  logic [POS_BITS-1:0]   hit_idx;
  logic [COUNT_BITS-1:0] hit_cnt;

  logic                  go;
  logic                  load;
  logic [COUNT_BITS:0]   sum;
  logic [COUNT_BITS-1:0] sum_sat;
  logic                  drop;
  logic [1:0]            res_status;
  logic [POS_BITS-1:0]   res_pos;
  logic [COUNT_BITS-1:0] res_cnt;
  logic [OCC_BITS-1:0]   total_d;

  assign req_i.ready = state_q == S_IDLE;
  assign go          = !out_valid_q || rsp_o.ready;
  assign load        = (state_q == S_APPLY) && go;

  // Id limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= (ID_BITS + 1)'(1) << ID_BITS;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Hold the request while it is worked on
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      act_q <= req_i.action;
      id_q  <= req_i.item_id;
      amt_q <= req_i.amount;
      all_q <= req_i.remove_all;
      bad_q <= {1'b0, req_i.item_id} >= limit_q;
    end
  end

  // Cell row; on a shift each cell from the shift index on takes its right neighbour's entry, the last keeping its own
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [ID_BITS-1:0]    nxt_id;
    logic [COUNT_BITS-1:0] nxt_cnt;
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign nxt_id  = cell_id[i];
      assign nxt_cnt = cell_cnt[i];
    end else begin : g_mid
      assign nxt_id  = cell_id[i+1];
      assign nxt_cnt = cell_cnt[i+1];
    end
    cit_cell #(
      .ID_BITS   (ID_BITS),
      .COUNT_BITS(COUNT_BITS),
      .POS_BITS  (POS_BITS),
      .OCC_BITS  (OCC_BITS),
      .INDEX     (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .idx_i      (cmd_idx),
      .id_i       (id_q),
      .count_i    (cmd_cnt),
      .total_i    (total_q),
      .nxt_id_i   (nxt_id),
      .nxt_count_i(nxt_cnt),
      .id_o       (cell_id[i]),
      .count_o    (cell_cnt[i]),
      .hit_o      (cell_hit[i])
    );
  end

  cit_gather #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .COUNT_BITS (COUNT_BITS),
    .POS_BITS   (POS_BITS)
  ) u_gather (
    .clk_i  (clk_i),
    .hit_i  (cell_hit),
    .count_i(cell_cnt),
    .hit_o  (hit),
    .idx_o  (hit_idx),
    .count_o(hit_cnt)
  );

  // Decide the action's outcome and the cell command
  always_comb begin
    sum        = {1'b0, hit_cnt} + {1'b0, amt_q};
    sum_sat    = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
    drop       = all_q || (amt_q >= hit_cnt);
    res_status = cit_pkg::StOk;
    res_pos    = '0;
    res_cnt    = '0;
    total_d    = total_q;
    cmd.op      = cit_pkg::CELL_NOP;
    cmd.compare = state_q == S_MATCH;
    cmd_idx     = hit_idx;
    cmd_cnt     = amt_q;
    if (act_q == cit_pkg::ActClear) begin
      total_d = '0;
    end else if (bad_q) begin
      res_status = cit_pkg::StInvalid;
    end else if (act_q == cit_pkg::ActAdd) begin
      if (hit) begin
        cmd.op  = cit_pkg::CELL_WRITE;
        cmd_cnt = sum_sat;
        res_pos = hit_idx;
        res_cnt = sum_sat;
      end else if (total_q == FullOcc) begin
        res_status = cit_pkg::StFull;
      end else begin
        cmd.op  = cit_pkg::CELL_APPEND;
        cmd_idx = total_q[POS_BITS-1:0];
        res_pos = total_q[POS_BITS-1:0];
        res_cnt = amt_q;
        total_d = total_q + OCC_BITS'(1);
      end
    end else if (!hit) begin
      res_status = cit_pkg::StAbsent;
    end else if (act_q == cit_pkg::ActRemove) begin
      res_pos = hit_idx;
      if (drop) begin
        cmd.op  = cit_pkg::CELL_SHIFT;
        total_d = total_q - OCC_BITS'(1);
      end else begin
        cmd.op  = cit_pkg::CELL_WRITE;
        cmd_cnt = hit_cnt - amt_q;
        res_cnt = hit_cnt - amt_q;
      end
    end else begin
      res_pos = hit_idx;
      res_cnt = hit_cnt;
    end
    // Hold the cells outside the apply step and while the result register is still occupied
    if (!load) begin
      cmd.op = cit_pkg::CELL_NOP;
    end
  end

  // Sequencer, occupancy and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      total_q      <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= cit_pkg::StOk;
      out_pos_q    <= '0;
      out_cnt_q    <= '0;
      out_occ_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (req_i.valid) state_q <= S_MATCH;
        end
        S_MATCH:  state_q <= S_GATHER;
        S_GATHER: state_q <= S_PICK;
        S_PICK:   state_q <= S_APPLY;
        S_APPLY: begin
          if (go) begin
            total_q <= total_d;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      // Load a fresh result, or drop the old one once it is transferred
      if (load) begin
        out_valid_q  <= 1'b1;
        out_status_q <= res_status;
        out_pos_q    <= res_pos;
        out_cnt_q    <= res_cnt;
        out_occ_q    <= total_d;
      end else if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.position     = out_pos_q;
  assign rsp_o.entry_amount = out_cnt_q;
  assign rsp_o.occupancy    = out_occ_q;

  // Occupancy never passes the table depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) total_q <= FullOcc)
    else $error("occupancy beyond table depth");

  // Ids in the table are unique, so at most one cell matches
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   state_q == S_GATHER |-> $onehot0(cell_hit))
    else $error("more than one cell matched");

  // A result appears only out of the apply step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $rose(out_valid_q) |-> $past(state_q == S_APPLY))
    else $error("result raised outside apply");

  // Occupancy only moves at the apply step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !$stable(total_q) |-> $past(state_q == S_APPLY))
    else $error("occupancy changed outside apply");

endmodule
